// ----- rtl/core/pula_pkg.sv -----
// ----------------------------------------------------------------------------
// pula_pkg
// Types and constants shared by the pixel unpack to luminance-alpha unit.
// ----------------------------------------------------------------------------
package pula_pkg;

	// Field widths of the configuration registers and state.
	localparam int MODE_W   = 2;
	localparam int DIM_W    = 13;
	localparam int ROWLEN_W = 14;
	localparam int ALIGN_W  = 4;
	localparam int POS_W    = 27;
	localparam int STRIDE_W = 14;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Saturation point of the byte position counter.
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Pair byte that stands for full coverage.
	localparam logic [7:0] BYTE_FULL = 8'hff;

	// Cycles from a register write until the layout check has settled.
	localparam logic [2:0] SETTLE_CYCLES = 3'd4;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ALIGNMENT  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_ROWS      = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_PIXELS    = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES   = 8'd7;

	// Transform modes.
	localparam logic [MODE_W-1:0] MODE_LUMINANCE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALPHA     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RED       = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WALK  = 2'd1,
		ST_DONE  = 2'd2,
		ST_ERROR = 2'd3
	} walk_status_t;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       buffer_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] first_out;
		logic [7:0] second_out;
		logic       last_pair;
		logic       layout_error;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_req_t;

	typedef struct packed {
		logic [MODE_W-1:0]   transform_mode;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic [ROWLEN_W-1:0] row_length;
		logic [ALIGN_W-1:0]  row_alignment;
		logic [DIM_W-1:0]    skip_rows;
		logic [ROWLEN_W-1:0] skip_pixels;
		logic [POS_W-1:0]    buffer_bytes;
	} cfg_regs_t;

	// Result of the layout check, latched by the walker at buffer start.
	typedef struct packed {
		logic                ok;
		logic [STRIDE_W-1:0] stride;
		logic [POS_W-1:0]    offset;
	} layout_t;

endpackage

// ----- rtl/core/pula_stream_if.sv -----
// ----------------------------------------------------------------------------
// pula_stream_if
// Valid/ready channel carrying one request payload per handshake.
// ----------------------------------------------------------------------------
interface pula_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pula_layout.sv -----
// ----------------------------------------------------------------------------
// pula_layout
// Four-stage pipeline that checks the unpack layout and derives stride and
// start offset from the configuration registers.
// ----------------------------------------------------------------------------
module pula_layout (
	input  logic                clk,
	input  pula_pkg::cfg_regs_t regs,
	output pula_pkg::layout_t   layout
);

	localparam int STR_W  = pula_pkg::STRIDE_W + 1;
	localparam int PROD_W = pula_pkg::DIM_W + STR_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int REQ_W  = SUM_W + 1;

	logic [pula_pkg::ALIGN_W-1:0]  align_m1;
	logic [pula_pkg::ROWLEN_W-1:0] pixels;
	logic [STR_W-1:0]              stride_sum;
	logic                          align_ok;
	logic                          dims_ok;
	logic                          fit_ok;

	logic             ok_s1;
	logic [STR_W-1:0] stride_s1;
	logic             ok_s2;
	logic [STR_W-1:0] stride_s2;
	logic [PROD_W-1:0] prod_skip_s2;
	logic [PROD_W-1:0] prod_rows_s2;
	logic             ok_s3;
	logic [STR_W-1:0] stride_s3;
	logic [SUM_W-1:0] offset_s3;
	logic [SUM_W-1:0] tail_s3;
	logic [REQ_W-1:0] required;

	// Stage one: alignment, dimension and row fit checks, and the stride.
	always_comb begin
		align_m1 = regs.row_alignment - 4'd1;
		align_ok = (regs.row_alignment == 4'd1) || (regs.row_alignment == 4'd2) ||
			(regs.row_alignment == 4'd4) || (regs.row_alignment == 4'd8);
		dims_ok = (regs.image_width != '0) && (regs.image_height != '0);
		pixels = (regs.row_length != '0) ? regs.row_length : {1'b0, regs.image_width};
		fit_ok = (pixels >= {1'b0, regs.image_width}) &&
			(regs.skip_pixels <= (pixels - {1'b0, regs.image_width}));
		stride_sum = {1'b0, pixels} + {{(STR_W-pula_pkg::ALIGN_W){1'b0}}, align_m1};
	end

	always_ff @(posedge clk) begin
		ok_s1 <= align_ok && dims_ok && fit_ok;
		stride_s1 <= stride_sum & ~{{(STR_W-pula_pkg::ALIGN_W){1'b0}}, align_m1};
	end

	// Stage two: skipped rows and image rows times the stride.
	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1;
		stride_s2 <= stride_s1;
		prod_skip_s2 <= {{STR_W{1'b0}}, regs.skip_rows} * {{pula_pkg::DIM_W{1'b0}}, stride_s1};
		prod_rows_s2 <= {{STR_W{1'b0}}, regs.image_height - 13'd1} *
			{{pula_pkg::DIM_W{1'b0}}, stride_s1};
	end

	// Stage three: start offset and the span of the image after it.
	always_ff @(posedge clk) begin
		ok_s3 <= ok_s2;
		stride_s3 <= stride_s2;
		offset_s3 <= {1'b0, prod_skip_s2} +
			{{(SUM_W-pula_pkg::ROWLEN_W){1'b0}}, regs.skip_pixels};
		tail_s3 <= {1'b0, prod_rows_s2} +
			{{(SUM_W-pula_pkg::DIM_W){1'b0}}, regs.image_width};
	end

	// Stage four: required bytes against the buffer size.
	assign required = {1'b0, offset_s3} + {1'b0, tail_s3};

	always_ff @(posedge clk) begin
		layout.ok <= ok_s3 &&
			(required <= {{(REQ_W-pula_pkg::POS_W){1'b0}}, regs.buffer_bytes});
		layout.stride <= stride_s3[pula_pkg::STRIDE_W-1:0];
		layout.offset <= offset_s3[pula_pkg::POS_W-1:0];
	end

endmodule

// ----- rtl/core/pula_walker.sv -----
// ----------------------------------------------------------------------------
// pula_walker
// Walks the image region over the incoming byte stream and registers one
// luminance-alpha pair or error result per accepted byte that yields one.
// ----------------------------------------------------------------------------
module pula_walker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hold,
	input  pula_pkg::cfg_regs_t  regs,
	input  pula_pkg::layout_t    layout,
	input  logic                 item_valid,
	input  pula_pkg::in_item_t   item,
	output logic                 item_ready,
	output logic                 res_valid,
	output pula_pkg::out_item_t  res,
	input  logic                 res_ready
);

	pula_pkg::walk_status_t        status_q;
	pula_pkg::walk_status_t        status_n;
	logic [pula_pkg::POS_W-1:0]    pos_q;
	logic [pula_pkg::POS_W-1:0]    pos_n;
	logic [pula_pkg::POS_W-1:0]    row_start_q;
	logic [pula_pkg::POS_W-1:0]    row_start_n;
	logic [pula_pkg::STRIDE_W-1:0] stride_q;
	logic [pula_pkg::STRIDE_W-1:0] stride_n;
	logic [pula_pkg::DIM_W-1:0]    row_q;
	logic [pula_pkg::DIM_W-1:0]    row_n;
	logic [pula_pkg::DIM_W-1:0]    col_q;
	logic [pula_pkg::DIM_W-1:0]    col_n;
	logic [pula_pkg::DIM_W-1:0]    col_inc;
	logic [pula_pkg::DIM_W-1:0]    row_inc;
	logic                          emit;
	logic                          take;
	logic                          res_valid_q;
	pula_pkg::out_item_t           res_n;
	pula_pkg::out_item_t           res_q;

	// A new byte is taken when src is not held off and the result register is free or drains.
	assign item_ready = !hold && (!res_valid_q || res_ready);
	assign take = item_valid && item_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Next walk state and result for the byte on the input.
	always_comb begin
		status_n = status_q;
		pos_n = pos_q;
		row_start_n = row_start_q;
		stride_n = stride_q;
		row_n = row_q;
		col_n = col_q;
		emit = 1'b0;
		res_n = '0;
		col_inc = '0;
		row_inc = '0;

		if (item.buffer_start && !layout.ok) begin
			// Rejected layout: one error result, then ignore the buffer.
			status_n = pula_pkg::ST_ERROR;
			pos_n = {{(pula_pkg::POS_W-1){1'b0}}, 1'b1};
			emit = 1'b1;
			res_n.last_pair = 1'b1;
			res_n.layout_error = 1'b1;
		end else begin
			if (item.buffer_start) begin
				status_n = pula_pkg::ST_WALK;
				pos_n = '0;
				row_start_n = layout.offset;
				stride_n = layout.stride;
				row_n = '0;
				col_n = '0;
			end
			if (status_n == pula_pkg::ST_WALK) begin
				if (pos_n != pula_pkg::POS_MAX) begin
					pos_n = pos_n + 27'd1;
				end
				// The position before the increment decides image membership.
				if ((item.buffer_start ? '0 : pos_q) >= row_start_n) begin
					emit = 1'b1;
					col_inc = col_n + 13'd1;
					if (col_inc >= regs.image_width) begin
						col_n = '0;
						row_inc = row_n + 13'd1;
						row_n = row_inc;
						row_start_n = row_start_n +
							{{(pula_pkg::POS_W-pula_pkg::STRIDE_W){1'b0}}, stride_n};
						if (row_inc >= regs.image_height) begin
							status_n = pula_pkg::ST_DONE;
							res_n.last_pair = 1'b1;
						end
					end else begin
						col_n = col_inc;
					end
					case (regs.transform_mode)
						pula_pkg::MODE_LUMINANCE: begin
							res_n.first_out = item.src_byte;
							res_n.second_out = pula_pkg::BYTE_FULL;
						end
						pula_pkg::MODE_RED: begin
							res_n.first_out = item.src_byte;
							res_n.second_out = item.src_byte;
						end
						default: begin
							res_n.first_out = pula_pkg::BYTE_FULL;
							res_n.second_out = item.src_byte;
						end
					endcase
				end
			end
		end
	end

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= pula_pkg::ST_IDLE;
			pos_q <= '0;
			row_start_q <= '0;
			stride_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			status_q <= status_n;
			pos_q <= pos_n;
			row_start_q <= row_start_n;
			stride_q <= stride_n;
			row_q <= row_n;
			col_q <= col_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_n;
		end
	end

endmodule

// ----- rtl/core/pixel_unpack_to_luminance_alpha_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_unpack_to_luminance_alpha_unit
// Expands the image bytes of an aligned client pixel buffer into
// luminance-alpha pairs, rejecting layouts that do not fit.
//
//   Channel  Role    Payload                                       Request
//   src      sink    src_byte, buffer_start                        one byte
//   dst      source  first_out, second_out, last_pair, layout_error one pair
//   cfg      sink    index, wdata                                  one write
//
// One byte per cycle is accepted while src is not held off; a pair appears
// in the result register the cycle after its byte. The per-byte path is
// one position compare and the column, row and row-start updates.
// After reset and after every register write, src is held off until the
// settle counter is zero, while the layout check pipeline (two multipliers,
// wide adds, buffer size compare) settles. Writes are accepted in every cycle.
// A stalled dst only holds src off while the result register is full.
// ----------------------------------------------------------------------------
module pixel_unpack_to_luminance_alpha_unit (
	input  logic               clk,
	input  logic               arst_n,
	pula_stream_if.sink        src,
	pula_stream_if.source      dst,
	pula_stream_if.sink        cfg
);

	pula_pkg::cfg_regs_t regs_q;
	pula_pkg::layout_t   layout;
	logic [2:0]          settle_q;
	logic                cfg_take;

	assign cfg.ready = 1'b1;
	assign cfg_take = cfg.valid && cfg.ready;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.transform_mode <= pula_pkg::MODE_LUMINANCE;
			regs_q.image_width <= 13'd1;
			regs_q.image_height <= 13'd1;
			regs_q.row_length <= '0;
			regs_q.row_alignment <= 4'd4;
			regs_q.skip_rows <= '0;
			regs_q.skip_pixels <= '0;
			regs_q.buffer_bytes <= '0;
		end else if (cfg_take) begin
			case (cfg.data.index)
				pula_pkg::REG_TRANSFORM_MODE: begin
					regs_q.transform_mode <= cfg.data.wdata[pula_pkg::MODE_W-1:0];
				end
				pula_pkg::REG_IMAGE_WIDTH: begin
					regs_q.image_width <= cfg.data.wdata[pula_pkg::DIM_W-1:0];
				end
				pula_pkg::REG_IMAGE_HEIGHT: begin
					regs_q.image_height <= cfg.data.wdata[pula_pkg::DIM_W-1:0];
				end
				pula_pkg::REG_ROW_LENGTH: begin
					regs_q.row_length <= cfg.data.wdata[pula_pkg::ROWLEN_W-1:0];
				end
				pula_pkg::REG_ROW_ALIGNMENT: begin
					regs_q.row_alignment <= cfg.data.wdata[pula_pkg::ALIGN_W-1:0];
				end
				pula_pkg::REG_SKIP_ROWS: begin
					regs_q.skip_rows <= cfg.data.wdata[pula_pkg::DIM_W-1:0];
				end
				pula_pkg::REG_SKIP_PIXELS: begin
					regs_q.skip_pixels <= cfg.data.wdata[pula_pkg::ROWLEN_W-1:0];
				end
				pula_pkg::REG_BUFFER_BYTES: begin
					regs_q.buffer_bytes <= cfg.data.wdata[pula_pkg::POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Settle counter: restarts on each write, counts down to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= pula_pkg::SETTLE_CYCLES;
		end else if (cfg_take) begin
			settle_q <= pula_pkg::SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	pula_layout u_layout (
		.clk    (clk),
		.regs   (regs_q),
		.layout (layout)
	);

	pula_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (settle_q != '0),
		.regs       (regs_q),
		.layout     (layout),
		.item_valid (src.valid),
		.item       (src.data),
		.item_ready (src.ready),
		.res_valid  (dst.valid),
		.res        (dst.data),
		.res_ready  (dst.ready)
	);

	// An error result carries zero pair bytes and closes the buffer.
	a_error_shape : assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && dst.data.layout_error) |->
		(dst.data.last_pair && (dst.data.first_out == '0) && (dst.data.second_out == '0)))
		else $error("error result with pair bytes or without last_pair");

	// A register write holds off input bytes until the layout has settled.
	a_write_holds : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_take |=> !src.ready)
		else $error("input accepted right after a register write");

	// The result register is never overwritten while it still waits.
	a_no_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		src.ready |-> (!dst.valid || dst.ready))
		else $error("input accepted while a result is stalled");

endmodule

// ----- verif/pixel_unpack_to_luminance_alpha_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_unpack_to_luminance_alpha_unit_test
// Self-checking bench for the pixel unpack to luminance-alpha unit. Layouts
// are programmed over the register channel, client buffers are streamed in
// with random bursts and gaps, and every pair that leaves the unit is checked
// against a cycle-free model of the image walk kept in a small scoreboard.
// ----------------------------------------------------------------------------
module pixel_unpack_to_luminance_alpha_unit_test;

	localparam int          CLK_PERIOD   = 8;
	localparam int          RESET_CYCLES = 6;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned SETTLE_PAD   = 8;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned NO_CAP       = 32'hffff_ffff;
	localparam int unsigned EDGE_CAP     = 64;
	localparam int unsigned REG_COUNT    = 8;
	localparam logic [pula_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [pula_pkg::POS_W-1:0]  BUFFER_MAX  = '1;

	// Receiver behavior over one stretch of cycles.
	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_style_t;

	// Tracks the register file and the image walk, and holds the pairs that
	// the unit still owes.
	class la_pair_scoreboard;
		pula_pkg::cfg_regs_t           regs;
		logic [pula_pkg::POS_W-1:0]    byte_pos;
		logic [pula_pkg::POS_W-1:0]    row_start;
		logic [pula_pkg::STRIDE_W-1:0] stride;
		logic [pula_pkg::DIM_W-1:0]    row_idx;
		logic [pula_pkg::DIM_W-1:0]    col_idx;
		pula_pkg::walk_status_t        status;
		pula_pkg::out_item_t           due_pairs[$];
		int unsigned                   failures;
		int unsigned                   bytes_seen;
		int unsigned                   results_predicted;
		int unsigned                   images_done;
		int unsigned                   rejects;

		function new();
			regs = '{transform_mode: pula_pkg::MODE_LUMINANCE, image_width: 1,
				image_height: 1, row_length: 0, row_alignment: 4, skip_rows: 0,
				skip_pixels: 0, buffer_bytes: 0};
			byte_pos = '0;
			row_start = '0;
			stride = '0;
			row_idx = '0;
			col_idx = '0;
			status = pula_pkg::ST_IDLE;
			failures = 0;
			bytes_seen = 0;
			results_predicted = 0;
			images_done = 0;
			rejects = 0;
		endfunction

		// Returns 1 when the layout fits, along with pitch, start offset and
		// the number of buffer bytes the image needs. Sums are 64 bits wide.
		static function bit fit_layout(input pula_pkg::cfg_regs_t r,
				output longint unsigned pitch, output longint unsigned start,
				output longint unsigned need);
			longint unsigned a;
			longint unsigned pixels;
			a = r.row_alignment;
			pitch = 0;
			start = 0;
			need = 0;
			if (a != 1 && a != 2 && a != 4 && a != 8)
				return 1'b0;
			if (r.image_width == 0 || r.image_height == 0)
				return 1'b0;
			pixels = (r.row_length != 0) ? r.row_length : r.image_width;
			if (pixels < r.image_width || r.skip_pixels > pixels - r.image_width)
				return 1'b0;
			pitch = (pixels + a - 1) & ~(a - 1);
			start = r.skip_rows * pitch + r.skip_pixels;
			need = start + (r.image_height - 1) * pitch + r.image_width;
			return need <= r.buffer_bytes;
		endfunction

		// Register writes keep only the bits of the field; unknown indexes
		// are dropped.
		function void write_register(input logic [pula_pkg::CFG_IDX_W-1:0] idx,
				input logic [pula_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				pula_pkg::REG_TRANSFORM_MODE:
					regs.transform_mode = data[pula_pkg::MODE_W-1:0];
				pula_pkg::REG_IMAGE_WIDTH:
					regs.image_width = data[pula_pkg::DIM_W-1:0];
				pula_pkg::REG_IMAGE_HEIGHT:
					regs.image_height = data[pula_pkg::DIM_W-1:0];
				pula_pkg::REG_ROW_LENGTH:
					regs.row_length = data[pula_pkg::ROWLEN_W-1:0];
				pula_pkg::REG_ROW_ALIGNMENT:
					regs.row_alignment = data[pula_pkg::ALIGN_W-1:0];
				pula_pkg::REG_SKIP_ROWS:
					regs.skip_rows = data[pula_pkg::DIM_W-1:0];
				pula_pkg::REG_SKIP_PIXELS:
					regs.skip_pixels = data[pula_pkg::ROWLEN_W-1:0];
				pula_pkg::REG_BUFFER_BYTES:
					regs.buffer_bytes = data[pula_pkg::POS_W-1:0];
				default: ;
			endcase
		endfunction

		// Advances the walk by one accepted source byte and queues the pair
		// that it produces, if any.
		function void predict_pair(input pula_pkg::in_item_t req);
			longint unsigned pitch;
			longint unsigned start;
			longint unsigned need;
			logic [pula_pkg::POS_W-1:0] here;
			pula_pkg::out_item_t pr;
			bytes_seen++;
			if (req.buffer_start) begin
				if (!fit_layout(regs, pitch, start, need)) begin
					status = pula_pkg::ST_ERROR;
					byte_pos = 1;
					pr = '{first_out: 8'h00, second_out: 8'h00, last_pair: 1'b1,
						layout_error: 1'b1};
					due_pairs.push_back(pr);
					results_predicted++;
					rejects++;
					return;
				end
				stride = pitch[pula_pkg::STRIDE_W-1:0];
				row_start = start[pula_pkg::POS_W-1:0];
				row_idx = '0;
				col_idx = '0;
				byte_pos = '0;
				status = pula_pkg::ST_WALK;
			end
			if (status != pula_pkg::ST_WALK)
				return;

			// Bytes before the start of the current row are skipped.
			here = byte_pos;
			if (byte_pos != pula_pkg::POS_MAX)
				byte_pos++;
			if (here < row_start)
				return;

			// Width, height and mode are read live; stride was latched.
			pr.last_pair = 1'b0;
			pr.layout_error = 1'b0;
			col_idx = col_idx + 1'b1;
			if (col_idx >= regs.image_width) begin
				col_idx = '0;
				row_idx = row_idx + 1'b1;
				row_start = row_start + stride;
				if (row_idx >= regs.image_height) begin
					status = pula_pkg::ST_DONE;
					pr.last_pair = 1'b1;
					images_done++;
				end
			end
			case (regs.transform_mode)
				pula_pkg::MODE_LUMINANCE: begin
					pr.first_out = req.src_byte;
					pr.second_out = pula_pkg::BYTE_FULL;
				end
				pula_pkg::MODE_RED: begin
					pr.first_out = req.src_byte;
					pr.second_out = req.src_byte;
				end
				default: begin
					pr.first_out = pula_pkg::BYTE_FULL;
					pr.second_out = req.src_byte;
				end
			endcase
			due_pairs.push_back(pr);
			results_predicted++;
		endfunction

		// Compares one pair leaving the unit with the oldest one owed.
		function void check_pair(input pula_pkg::out_item_t got);
			pula_pkg::out_item_t want;
			if (due_pairs.size() == 0) begin
				failures++;
				$display("%0t: unexpected pair: first %02h second %02h last %0b error %0b",
					$time, got.first_out, got.second_out, got.last_pair, got.layout_error);
				return;
			end
			want = due_pairs.pop_front();
			if (got !== want) begin
				failures++;
				$display("%0t: pair mismatch: expected first %02h second %02h last %0b error %0b",
					$time, want.first_out, want.second_out, want.last_pair, want.layout_error);
				$display("%0t:                  actual first %02h second %02h last %0b error %0b",
					$time, got.first_out, got.second_out, got.last_pair, got.layout_error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pula_stream_if #(.payload_t(pula_pkg::in_item_t))  src_ch ();
	pula_stream_if #(.payload_t(pula_pkg::out_item_t)) dst_ch ();
	pula_stream_if #(.payload_t(pula_pkg::cfg_req_t))  cfg_ch ();

	la_pair_scoreboard sb = new();

	int unsigned bytes_pushed = 0;
	int unsigned settings_written = 0;
	int unsigned burst_left = 0;
	bit          gappy = 1'b1;

	pixel_unpack_to_luminance_alpha_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.dst    (dst_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Every accepted request on any channel goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_register(cfg_ch.data.index, cfg_ch.data.wdata);
			if (src_ch.valid && src_ch.ready)
				sb.predict_pair(src_ch.data);
			if (dst_ch.valid && dst_ch.ready)
				sb.check_pair(dst_ch.data);
		end
	end

	// The receiver changes its stall behavior after each stretch of random length.
	initial begin : receiver_pattern
		int unsigned stretch;
		int unsigned tick;
		flow_style_t style;
		dst_ch.ready = 1'b0;
		stretch = 0;
		tick = 0;
		style = FLOW_FREE;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(16, 160);
				style = flow_style_t'($urandom_range(0, 3));
			end
			stretch--;
			tick++;
			case (style)
				FLOW_FREE:  dst_ch.ready = 1'b1;
				FLOW_LIGHT: dst_ch.ready = ($urandom_range(0, 3) != 0);
				FLOW_HEAVY: dst_ch.ready = ($urandom_range(0, 3) == 0);
				default:    dst_ch.ready = ((tick % 7) < 3);
			endcase
		end
	end

	// Ends the run when no request is accepted on any channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog: no request accepted for %0d cycles", $time, STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// One register write request; valid stays high for a following write.
	task automatic write_reg(input logic [pula_pkg::CFG_IDX_W-1:0] idx,
			input logic [pula_pkg::CFG_DATA_W-1:0] value, input int unsigned width);
		logic [pula_pkg::CFG_DATA_W-1:0] junk;
		pula_pkg::cfg_req_t req;
		junk = '0;
		if ($urandom_range(0, 2) == 0 && width < pula_pkg::CFG_DATA_W)
			junk = $urandom << width;
		req.index = idx;
		req.wdata = value | junk;
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = req;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	// Writes the whole register set, sometimes after a write to an index
	// past the end of the register file.
	task automatic program_layout(input pula_pkg::cfg_regs_t r);
		if ($urandom_range(0, 3) == 0)
			write_reg(pula_pkg::CFG_IDX_W'($urandom_range(REG_COUNT, 255)), $urandom, 0);
		write_reg(pula_pkg::REG_TRANSFORM_MODE,
			pula_pkg::CFG_DATA_W'(r.transform_mode), pula_pkg::MODE_W);
		write_reg(pula_pkg::REG_IMAGE_WIDTH,
			pula_pkg::CFG_DATA_W'(r.image_width), pula_pkg::DIM_W);
		write_reg(pula_pkg::REG_IMAGE_HEIGHT,
			pula_pkg::CFG_DATA_W'(r.image_height), pula_pkg::DIM_W);
		write_reg(pula_pkg::REG_ROW_LENGTH,
			pula_pkg::CFG_DATA_W'(r.row_length), pula_pkg::ROWLEN_W);
		write_reg(pula_pkg::REG_ROW_ALIGNMENT,
			pula_pkg::CFG_DATA_W'(r.row_alignment), pula_pkg::ALIGN_W);
		write_reg(pula_pkg::REG_SKIP_ROWS,
			pula_pkg::CFG_DATA_W'(r.skip_rows), pula_pkg::DIM_W);
		write_reg(pula_pkg::REG_SKIP_PIXELS,
			pula_pkg::CFG_DATA_W'(r.skip_pixels), pula_pkg::ROWLEN_W);
		write_reg(pula_pkg::REG_BUFFER_BYTES,
			pula_pkg::CFG_DATA_W'(r.buffer_bytes), pula_pkg::POS_W);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		settings_written++;
	endtask

	// Sends one source byte; bursts of random length are separated by gaps.
	task automatic push_byte(input logic first);
		pula_pkg::in_item_t req;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gappy ? $urandom_range(0, 5) : 0;
			repeat (gap) begin
				@(negedge clk);
				src_ch.valid = 1'b0;
			end
			if ($urandom_range(0, 15) == 0)
				gappy = !gappy;
		end
		burst_left--;
		case ($urandom_range(0, 7))
			0:       req.src_byte = 8'h00;
			1:       req.src_byte = 8'hff;
			default: req.src_byte = 8'($urandom);
		endcase
		req.buffer_start = first;
		@(negedge clk);
		src_ch.valid = 1'b1;
		src_ch.data = req;
		@(posedge clk);
		while (!src_ch.ready)
			@(posedge clk);
		bytes_pushed++;
	endtask

	// Holds the sender until every owed pair has arrived, then lets the
	// unit finish any byte that produced nothing.
	task automatic hold_until_drained();
		@(negedge clk);
		src_ch.valid = 1'b0;
		while (sb.due_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_PAD)
			@(posedge clk);
	endtask

	// Programs a layout and streams one buffer for it, at most cap bytes.
	task automatic run_image(input pula_pkg::cfg_regs_t r, input int unsigned extra,
			input int unsigned cap);
		longint unsigned pitch;
		longint unsigned start;
		longint unsigned need;
		longint unsigned len;
		hold_until_drained();
		program_layout(r);
		if (la_pair_scoreboard::fit_layout(r, pitch, start, need))
			len = need + extra;
		else
			len = 1 + extra;
		if (len > cap)
			len = cap;
		for (longint unsigned i = 0; i < len; i++)
			push_byte(i == 0);
	endtask

	// Draws a small layout; about one in three is broken in one way.
	function automatic pula_pkg::cfg_regs_t draw_layout();
		pula_pkg::cfg_regs_t r;
		longint unsigned pitch;
		longint unsigned start;
		longint unsigned need;
		longint unsigned pixels;
		r = '0;
		r.transform_mode = pula_pkg::MODE_W'($urandom_range(0, 3));
		r.image_width = pula_pkg::DIM_W'($urandom_range(1, 6));
		r.image_height = pula_pkg::DIM_W'($urandom_range(1, 4));
		if ($urandom_range(0, 2) != 0)
			r.row_length = pula_pkg::ROWLEN_W'(r.image_width + $urandom_range(0, 5));
		r.row_alignment = pula_pkg::ALIGN_W'(1 << $urandom_range(0, 3));
		pixels = (r.row_length != 0) ? r.row_length : r.image_width;
		r.skip_rows = pula_pkg::DIM_W'($urandom_range(0, 2));
		r.skip_pixels = pula_pkg::ROWLEN_W'($urandom_range(0, int'(pixels - r.image_width)));
		r.buffer_bytes = BUFFER_MAX;
		void'(la_pair_scoreboard::fit_layout(r, pitch, start, need));
		r.buffer_bytes = pula_pkg::POS_W'(need + $urandom_range(0, 3));
		case ($urandom_range(0, 17))
			0: r.buffer_bytes = pula_pkg::POS_W'(need - 1);
			1: begin
				do
					r.row_alignment = pula_pkg::ALIGN_W'($urandom);
				while (r.row_alignment inside {1, 2, 4, 8});
			end
			2: begin
				r.row_length = pula_pkg::ROWLEN_W'($urandom_range(1, r.image_width));
				r.image_width = r.image_width + 1'b1;
			end
			3: r.skip_pixels = pula_pkg::ROWLEN_W'(pixels - r.image_width + 1);
			4: r.image_width = '0;
			5: r.image_height = '0;
			default: ;
		endcase
		return r;
	endfunction

	initial begin : stimulus
		pula_pkg::cfg_regs_t lay;
		pula_pkg::cfg_regs_t base;
		longint unsigned pitch;
		longint unsigned start;
		longint unsigned need;
		longint unsigned len;
		bit fits;
		int unsigned nbuf;
		int unsigned bytes_base;

		arst_n = 1'b0;
		src_ch.valid = 1'b0;
		src_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n = 1'b1;

		// Reset registers: bytes before any buffer are ignored, an empty
		// buffer is rejected, and bytes after the reject are ignored.
		push_byte(1'b0);
		push_byte(1'b0);
		push_byte(1'b1);
		push_byte(1'b0);

		// Skipped rows and pixels, two rows, one trailing byte.
		base = '{transform_mode: pula_pkg::MODE_LUMINANCE, image_width: 2, image_height: 2,
			row_length: 3, row_alignment: 1, skip_rows: 1, skip_pixels: 1,
			buffer_bytes: 9};
		run_image(base, 1, NO_CAP);

		// The other transform modes, including the unused code.
		lay = '{transform_mode: pula_pkg::MODE_ALPHA, image_width: 1, image_height: 1,
			row_length: 0, row_alignment: 8, skip_rows: 0, skip_pixels: 0,
			buffer_bytes: 1};
		run_image(lay, 0, NO_CAP);
		lay.transform_mode = pula_pkg::MODE_RED;
		run_image(lay, 0, NO_CAP);
		lay.transform_mode = MODE_UNUSED;
		run_image(lay, 0, NO_CAP);

		// Each way a layout is rejected.
		lay = base;
		lay.row_alignment = 3;
		run_image(lay, 1, NO_CAP);
		lay = base;
		lay.image_width = 0;
		run_image(lay, 0, NO_CAP);
		lay = base;
		lay.image_height = 0;
		run_image(lay, 0, NO_CAP);
		lay = base;
		lay.row_length = 1;
		run_image(lay, 0, NO_CAP);
		lay = base;
		lay.skip_pixels = 2;
		run_image(lay, 0, NO_CAP);
		lay = base;
		lay.buffer_bytes = 8;
		run_image(lay, 0, NO_CAP);

		// The start of a 4096-pixel row and of a 4096-row column.
		lay = '{transform_mode: pula_pkg::MODE_RED, image_width: 4096, image_height: 1,
			row_length: 0, row_alignment: 1, skip_rows: 0, skip_pixels: 0,
			buffer_bytes: 4096};
		run_image(lay, 1, EDGE_CAP);
		lay = '{transform_mode: pula_pkg::MODE_LUMINANCE, image_width: 1,
			image_height: 4096, row_length: 0, row_alignment: 1, skip_rows: 0,
			skip_pixels: 0, buffer_bytes: 4096};
		run_image(lay, 0, EDGE_CAP);

		// A pitch that wraps the stride field to zero: every row restarts at
		// the same byte position.
		lay = '{transform_mode: pula_pkg::MODE_ALPHA, image_width: 1, image_height: 2,
			row_length: 16383, row_alignment: 8, skip_rows: 0, skip_pixels: 0,
			buffer_bytes: 16385};
		run_image(lay, 0, 4);

		// Largest skip into the largest buffer; only the skip is reached.
		lay = '{transform_mode: pula_pkg::MODE_ALPHA, image_width: 1, image_height: 1,
			row_length: 16383, row_alignment: 1, skip_rows: 8191, skip_pixels: 16382,
			buffer_bytes: BUFFER_MAX};
		run_image(lay, 0, 5);

		// All fields at their top values, then a widest row one byte short.
		lay = '{transform_mode: MODE_UNUSED, image_width: 8191, image_height: 8191,
			row_length: 16383, row_alignment: 15, skip_rows: 8191, skip_pixels: 16383,
			buffer_bytes: BUFFER_MAX};
		run_image(lay, 1, NO_CAP);
		lay = '{transform_mode: pula_pkg::MODE_RED, image_width: 8191, image_height: 1,
			row_length: 0, row_alignment: 1, skip_rows: 0, skip_pixels: 0,
			buffer_bytes: 8190};
		run_image(lay, 0, NO_CAP);

		// Random layouts, mostly whole buffers, some truncated, some
		// continued under new registers without a buffer start.
		bytes_base = bytes_pushed;
		while (bytes_pushed - bytes_base < RANDOM_ITEMS) begin
			lay = draw_layout();
			hold_until_drained();
			program_layout(lay);
			fits = la_pair_scoreboard::fit_layout(lay, pitch, start, need);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3))
					push_byte(1'b0);
			nbuf = $urandom_range(1, 3);
			for (int unsigned b = 0; b < nbuf; b++) begin
				if (!fits)
					len = $urandom_range(1, 3);
				else if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, int'(need));
				else
					len = need + $urandom_range(0, 3);
				for (longint unsigned i = 0; i < len; i++)
					push_byte(i == 0);
				if ($urandom_range(0, 15) == 0)
					hold_until_drained();
			end
		end

		hold_until_drained();
		if (sb.due_pairs.size() != 0)
			$display("%0t: %0d expected pairs never arrived", $time, sb.due_pairs.size());
		$display("Streamed %0d source bytes under %0d register settings, all modes included.",
			sb.bytes_seen, settings_written);
		$display("Predicted %0d results: %0d finished images and %0d rejected layouts.",
			sb.results_predicted, sb.images_done, sb.rejects);
		if (sb.failures == 0 && sb.due_pairs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/pula_pkg.sv
rtl/core/pula_stream_if.sv
rtl/core/pula_layout.sv
rtl/core/pula_walker.sv
rtl/core/pixel_unpack_to_luminance_alpha_unit.sv
verif/pixel_unpack_to_luminance_alpha_unit_test.sv
